@@ sv/ssfr_pkg.sv @@
// Shared types and constants for the sync-sum frame receiver.
package ssfr_pkg;

    // Frame layout: sync byte, payload bytes, checksum byte.
    localparam int unsigned PAYLOAD_LEN  = 20;
    localparam int unsigned NUM_WORDS    = PAYLOAD_LEN / 4;
    localparam int unsigned IDX_W        = $clog2(PAYLOAD_LEN + 1);
    localparam int unsigned SEQ_WORD_IDX = 3;

    // Configuration port geometry and reset values.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [7:0]  SYNC_RESET    = 8'hAA;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD_SUM  = 2'd1,
        ST_TIMEOUT  = 2'd2
    } t_status;

    // One result word as produced by the framer.
    typedef struct packed {
        t_status            status;
        logic signed [31:0] x_cmd;
        logic signed [31:0] y_cmd;
        logic signed [31:0] rot_cmd;
        logic signed [31:0] seq_word;
        logic signed [31:0] aux_word;
        logic               seq_skipped;
        logic signed [31:0] expected_seq;
    } t_result;

endpackage

@@ sv/sync_sum_frame_receiver_core.sv @@
// Top level of the sync-sum frame receiver: input register, framer, result register.
// A word is held in the input register, and its result then in the result register.
// Throughput: one word per cycle while the result channel is not stalled; the framer handles each word in one pass.
// The input register and result register decouple the two handshakes.
// Reset is synchronous, active low; it clears control state and loads the
// register defaults. Payload bytes are not reset.
module sync_sum_frame_receiver_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ssfr_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ssfr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_kind,
    input  logic [7:0]                            i_rx_byte,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [1:0]                            o_status,
    output logic signed [31:0]                    o_x_cmd,
    output logic signed [31:0]                    o_y_cmd,
    output logic signed [31:0]                    o_rot_cmd,
    output logic signed [31:0]                    o_seq_word,
    output logic signed [31:0]                    o_aux_word,
    output logic                                  o_seq_skipped,
    output logic signed [31:0]                    o_expected_seq
);

    logic [7:0]         r_sync_value;
    logic [15:0]        r_timeout_ticks;
    logic               r_in_valid;
    logic               r_in_kind;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    ssfr_pkg::t_result  r_out;
    logic               w_advance;
    logic               w_accept;
    logic               w_res_valid;
    ssfr_pkg::t_result  w_res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value    <= ssfr_pkg::SYNC_RESET;
            r_timeout_ticks <= ssfr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssfr_pkg::CFG_SYNC_VALUE:    r_sync_value    <= i_cfg_data[7:0];
                ssfr_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // The held word moves on when the result register is free or being emptied.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_accept   = i_in_valid && o_in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_rx_byte;
        end
    end

    ssfr_framer u_framer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_advance),
        .i_kind          (r_in_kind),
        .i_byte          (r_in_byte),
        .i_sync_value    (r_sync_value),
        .i_timeout_ticks (r_timeout_ticks),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_x_cmd        = r_out.x_cmd;
    assign o_y_cmd        = r_out.y_cmd;
    assign o_rot_cmd      = r_out.rot_cmd;
    assign o_seq_word     = r_out.seq_word;
    assign o_aux_word     = r_out.aux_word;
    assign o_seq_skipped  = r_out.seq_skipped;
    assign o_expected_seq = r_out.expected_seq;

`ifndef ASSERT_OFF
    // A timeout or checksum error never carries motion words.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ssfr_pkg::ST_GOOD) |->
        (o_x_cmd == '0 && o_y_cmd == '0 && o_rot_cmd == '0 &&
         o_seq_word == '0 && o_aux_word == '0 && !o_seq_skipped))
        else $error("error result carries payload");

    // A held input word that cannot advance is kept.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("held input word lost");

    // Ready is low only while a word waits behind a stalled result.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without cause");

    // A stalled result is not overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_expected_seq)))
        else $error("stalled result changed");
`endif

endmodule

@@ sv/ssfr_framer.sv @@
// Frame state machine, payload shift register, checksum and sequence tracking.
module ssfr_framer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_kind,
    input  logic [7:0]           i_byte,
    input  logic [7:0]           i_sync_value,
    input  logic [15:0]          i_timeout_ticks,
    output logic                 o_res_valid,
    output ssfr_pkg::t_result    o_res
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DATA = 2'd1,
        PH_SUM  = 2'd2
    } t_phase;

    localparam int unsigned PL = ssfr_pkg::PAYLOAD_LEN;
    localparam int unsigned IW = ssfr_pkg::IDX_W;
    localparam int unsigned NW = ssfr_pkg::NUM_WORDS;

    t_phase          r_phase, n_phase;
    logic [IW-1:0]   r_idx, n_idx;
    logic [7:0]      r_sum, n_sum;
    logic [31:0]     r_last_seq, n_last_seq;
    logic [31:0]     r_exp_seq, n_exp_seq;
    logic [15:0]     r_idle, n_idle;
    logic            r_to_rep, n_to_rep;
    logic [7:0]      r_pay [PL];
    logic            w_shift;
    logic [31:0]     w_words [NW];

    // Assemble the little-endian payload words from the shift register.
    always_comb begin
        for (int j = 0; j < NW; j++) begin
            w_words[j] = {r_pay[4*j+3], r_pay[4*j+2], r_pay[4*j+1], r_pay[4*j]};
        end
    end

    // Next-state and result logic for one word.
    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_sum      = r_sum;
        n_last_seq = r_last_seq;
        n_exp_seq  = r_exp_seq;
        n_idle     = r_idle;
        n_to_rep   = r_to_rep;
        w_shift    = 1'b0;
        o_res_valid = 1'b0;
        o_res              = '0;
        o_res.expected_seq = r_exp_seq;
        if (i_step) begin
            if (i_kind) begin
                // Tick: count idle time and report one timeout.
                if (!r_to_rep) begin
                    if (r_idle != 16'hFFFF) begin
                        n_idle = r_idle + 16'd1;
                    end
                    if (n_idle >= i_timeout_ticks) begin
                        n_to_rep     = 1'b1;
                        o_res_valid  = 1'b1;
                        o_res.status = ssfr_pkg::ST_TIMEOUT;
                    end
                end
            end else begin
                n_idle   = '0;
                n_to_rep = 1'b0;
                unique case (r_phase)
                    PH_HUNT: begin
                        if (i_byte == i_sync_value) begin
                            n_sum   = i_byte;
                            n_idx   = '0;
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        w_shift = 1'b1;
                        n_sum   = r_sum + i_byte;
                        n_idx   = r_idx + IW'(1);
                        if (r_idx == IW'(PL - 1)) begin
                            n_phase = PH_SUM;
                        end
                    end
                    PH_SUM: begin
                        n_phase     = PH_HUNT;
                        n_idx       = '0;
                        o_res_valid = 1'b1;
                        if (i_byte == r_sum) begin
                            o_res.status   = ssfr_pkg::ST_GOOD;
                            o_res.x_cmd    = w_words[0];
                            o_res.y_cmd    = w_words[1];
                            o_res.rot_cmd  = w_words[2];
                            o_res.seq_word = w_words[ssfr_pkg::SEQ_WORD_IDX];
                            o_res.aux_word = w_words[4];
                            o_res.seq_skipped = (r_last_seq != '0) &&
                                (w_words[ssfr_pkg::SEQ_WORD_IDX] != r_exp_seq);
                            n_last_seq = w_words[ssfr_pkg::SEQ_WORD_IDX];
                            n_exp_seq  = w_words[ssfr_pkg::SEQ_WORD_IDX] + 32'd1;
                        end else begin
                            o_res.status = ssfr_pkg::ST_BAD_SUM;
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                        n_idx   = '0;
                    end
                endcase
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_idx      <= '0;
            r_sum      <= '0;
            r_last_seq <= '0;
            r_exp_seq  <= 32'd1;
            r_idle     <= '0;
            r_to_rep   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_sum      <= n_sum;
            r_last_seq <= n_last_seq;
            r_exp_seq  <= n_exp_seq;
            r_idle     <= n_idle;
            r_to_rep   <= n_to_rep;
        end
    end

    // Payload bytes shift in at the top; the first byte ends up at entry zero.
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            for (int i = 0; i < PL - 1; i++) begin
                r_pay[i] <= r_pay[i+1];
            end
            r_pay[PL-1] <= i_byte;
        end
    end

endmodule

@@ tb/sv/deframer_checker.sv @@
// Checker for the sync-sum frame receiver: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps

module deframer_checker
    import ssfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_kind,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [1:0]            i_status,
    input  logic signed [31:0]    i_x_cmd,
    input  logic signed [31:0]    i_y_cmd,
    input  logic signed [31:0]    i_rot_cmd,
    input  logic signed [31:0]    i_seq_word,
    input  logic signed [31:0]    i_aux_word,
    input  logic                  i_seq_skipped,
    input  logic signed [31:0]    i_expected_seq,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_good_count,
    output int                    o_bad_sum_count,
    output int                    o_timeout_count,
    output int                    o_skip_count
);

    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        RX_HUNT     = 2'd0,
        RX_COLLECT  = 2'd1,
        RX_CHECKSUM = 2'd2
    } t_rx_phase;

    // Shadow copy of the receiver state and its registers.
    t_rx_phase        rx_phase;
    logic [IDX_W-1:0] payload_count;
    logic [7:0]       sum_acc;
    logic [7:0]       payload_bytes [PAYLOAD_LEN];
    logic [31:0]      prev_seq;
    logic [15:0]      idle_ticks;
    logic             timeout_flag;
    logic [7:0]       sync_byte;
    logic [15:0]      timeout_limit;

    // Results predicted but not yet seen on the output channel.
    t_result awaited_results [$];

    int fail_total;
    int good_total;
    int bad_sum_total;
    int timeout_total;
    int skip_total;

    // Applies one received byte or tick to the shadow state; returns 1 when a result is due.
    function automatic logic deframe_event(input logic kind, input logic [7:0] rx,
                                           output t_result res);
        logic [31:0] next_seq;
        logic [31:0] words [NUM_WORDS];
        int          w;
        next_seq = prev_seq + 32'd1;
        res = '0;
        res.expected_seq = next_seq;

        // A tick only advances the idle counter; one timeout per silent stretch.
        if (kind) begin
            if (timeout_flag)
                return 1'b0;
            if (idle_ticks != 16'hFFFF)
                idle_ticks = idle_ticks + 16'd1;
            if (idle_ticks >= timeout_limit) begin
                timeout_flag = 1'b1;
                res.status = ST_TIMEOUT;
                return 1'b1;
            end
            return 1'b0;
        end

        idle_ticks = '0;
        timeout_flag = 1'b0;

        case (rx_phase)
            RX_HUNT: begin
                if (rx == sync_byte) begin
                    sum_acc = rx;
                    payload_count = '0;
                    rx_phase = RX_COLLECT;
                end
                return 1'b0;
            end
            RX_COLLECT: begin
                payload_bytes[payload_count] = rx;
                sum_acc = sum_acc + rx;
                payload_count = payload_count + 1'b1;
                if (payload_count >= PAYLOAD_LEN)
                    rx_phase = RX_CHECKSUM;
                return 1'b0;
            end
            default: begin
                rx_phase = RX_HUNT;
                payload_count = '0;
                if (rx != sum_acc) begin
                    res.status = ST_BAD_SUM;
                    return 1'b1;
                end
                // Payload words are little-endian, four bytes each.
                for (w = 0; w < NUM_WORDS; w++) begin
                    words[w] = {payload_bytes[4*w+3], payload_bytes[4*w+2],
                                payload_bytes[4*w+1], payload_bytes[4*w]};
                end
                res.status      = ST_GOOD;
                res.x_cmd       = words[0];
                res.y_cmd       = words[1];
                res.rot_cmd     = words[2];
                res.seq_word    = words[SEQ_WORD_IDX];
                res.aux_word    = words[4];
                res.seq_skipped = (prev_seq != 32'd0) && (words[SEQ_WORD_IDX] != next_seq);
                prev_seq = words[SEQ_WORD_IDX];
                return 1'b1;
            end
        endcase
    endfunction

    function automatic string show_result(input t_result r);
        return $sformatf("status=%0d x=%h y=%h rot=%h seq=%h aux=%h skip=%b exp_seq=%h",
                         r.status, r.x_cmd, r.y_cmd, r.rot_cmd, r.seq_word, r.aux_word,
                         r.seq_skipped, r.expected_seq);
    endfunction

    task automatic report_failure(input string what);
        fail_total++;
        if (fail_total <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endtask

    // Sample everything at the rising edge, before the edge's own updates land.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        string   bad_fields;
        if (!i_rst_n) begin
            rx_phase      = RX_HUNT;
            payload_count = '0;
            sum_acc       = '0;
            prev_seq      = '0;
            idle_ticks    = '0;
            timeout_flag  = 1'b0;
            sync_byte     = SYNC_RESET;
            timeout_limit = TIMEOUT_RESET;
            awaited_results.delete();
        end else begin
            // Register writes.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYNC_VALUE:    sync_byte = i_cfg_data[7:0];
                    CFG_TIMEOUT_TICKS: timeout_limit = i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // Compare an accepted result with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                got.status       = t_status'(i_status);
                got.x_cmd        = i_x_cmd;
                got.y_cmd        = i_y_cmd;
                got.rot_cmd      = i_rot_cmd;
                got.seq_word     = i_seq_word;
                got.aux_word     = i_aux_word;
                got.seq_skipped  = i_seq_skipped;
                got.expected_seq = i_expected_seq;
                if (awaited_results.size() == 0) begin
                    report_failure({"unexpected result: ", show_result(got)});
                end else begin
                    want = awaited_results.pop_front();
                    bad_fields = "";
                    if (got.status !== want.status)             bad_fields = {bad_fields, " status"};
                    if (got.x_cmd !== want.x_cmd)               bad_fields = {bad_fields, " x_cmd"};
                    if (got.y_cmd !== want.y_cmd)               bad_fields = {bad_fields, " y_cmd"};
                    if (got.rot_cmd !== want.rot_cmd)           bad_fields = {bad_fields, " rot_cmd"};
                    if (got.seq_word !== want.seq_word)         bad_fields = {bad_fields, " seq_word"};
                    if (got.aux_word !== want.aux_word)         bad_fields = {bad_fields, " aux_word"};
                    if (got.seq_skipped !== want.seq_skipped)   bad_fields = {bad_fields, " seq_skipped"};
                    if (got.expected_seq !== want.expected_seq) bad_fields = {bad_fields, " expected_seq"};
                    if (bad_fields != "") begin
                        report_failure({"mismatch in", bad_fields, "\n    expected ",
                                        show_result(want), "\n    actual   ", show_result(got)});
                    end
                    case (want.status)
                        ST_GOOD:    good_total++;
                        ST_BAD_SUM: bad_sum_total++;
                        default:    timeout_total++;
                    endcase
                    if (want.seq_skipped)
                        skip_total++;
                end
            end

            // Predict the result of an accepted input word.
            if (i_in_valid && i_in_ready) begin
                if (deframe_event(i_kind, i_rx_byte, want))
                    awaited_results.push_back(want);
            end
        end

        o_fail_count    <= fail_total;
        o_pending       <= awaited_results.size();
        o_good_count    <= good_total;
        o_bad_sum_count <= bad_sum_total;
        o_timeout_count <= timeout_total;
        o_skip_count    <= skip_total;
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the frame receiver testbench: clock, reset, stimulus, flow control and the verdict.
`timescale 1ns / 1ps

module testbench;
    import ssfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int SEGMENT_ITEMS  = 190;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  in_kind = 1'b0;
    logic [7:0]            in_rx_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            status;
    logic signed [31:0]    x_cmd;
    logic signed [31:0]    y_cmd;
    logic signed [31:0]    rot_cmd;
    logic signed [31:0]    seq_word;
    logic signed [31:0]    aux_word;
    logic                  seq_skipped;
    logic signed [31:0]    expected_seq;

    int fail_count;
    int pending;
    int good_count;
    int bad_sum_count;
    int timeout_count;
    int skip_count;

    // Flow-control pressure, in percent of cycles.
    int send_gap_pct = 32;
    int recv_stall_pct = 73;

    // Stimulus bookkeeping.
    int          items_sent;
    int          words_sent;
    int          frames_sent;
    int          quiet_cycles;
    logic [7:0]  cur_sync = SYNC_RESET;
    logic [15:0] cur_timeout = TIMEOUT_RESET;
    logic [31:0] last_sent_seq;

    sync_sum_frame_receiver_core DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_kind         (in_kind),
        .i_rx_byte      (in_rx_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_status       (status),
        .o_x_cmd        (x_cmd),
        .o_y_cmd        (y_cmd),
        .o_rot_cmd      (rot_cmd),
        .o_seq_word     (seq_word),
        .o_aux_word     (aux_word),
        .o_seq_skipped  (seq_skipped),
        .o_expected_seq (expected_seq)
    );

    deframer_checker frame_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_kind          (in_kind),
        .i_rx_byte       (in_rx_byte),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_status        (status),
        .i_x_cmd         (x_cmd),
        .i_y_cmd         (y_cmd),
        .i_rot_cmd       (rot_cmd),
        .i_seq_word      (seq_word),
        .i_aux_word      (aux_word),
        .i_seq_skipped   (seq_skipped),
        .i_expected_seq  (expected_seq),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_good_count    (good_count),
        .o_bad_sum_count (bad_sum_count),
        .o_timeout_count (timeout_count),
        .o_skip_count    (skip_count)
    );

    // 8 ns clock.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver side: random stalls on the result channel.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: too long without any word moving on either channel ends the run.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles.", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one word (byte or tick) after a random gap and waits for its acceptance.
    task automatic send_word(input logic kind, input logic [7:0] data_byte, input bit counted);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_kind    <= kind;
        in_rx_byte <= data_byte;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if (counted)
            items_sent++;
    endtask

    // Sends sync, 20 payload bytes and the checksum, with optional ticks in between.
    task automatic send_frame(input logic [7:0] sync, input logic [159:0] payload,
                              input bit corrupt, input int tick_pct);
        logic [7:0] sum;
        int         j;
        sum = sync;
        send_word(1'b0, sync, 1'b1);
        for (j = 0; j < PAYLOAD_LEN; j++) begin
            if ($urandom_range(99) < tick_pct)
                send_word(1'b1, 8'($urandom), 1'b1);
            send_word(1'b0, payload[8*j +: 8], 1'b1);
            sum = sum + payload[8*j +: 8];
        end
        if ($urandom_range(99) < tick_pct)
            send_word(1'b1, 8'($urandom), 1'b1);
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_word(1'b0, sum, 1'b1);
        frames_sent++;
    endtask

    // Holds the sender off until every predicted result is out and the pipeline is empty.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers back to back; only called while the block is idle.
    task automatic write_config(input logic [7:0] sync, input logic [15:0] ticks);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SYNC_VALUE;
        cfg_data <= {8'h00, sync};
        @(posedge clk);
        cfg_idx  <= CFG_TIMEOUT_TICKS;
        cfg_data <= ticks;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_sync = sync;
        cur_timeout = ticks;
    endtask

    // Mostly well-formed frames with random content, mixed with noise, tick runs and cut frames.
    task automatic random_traffic(input int quota);
        int          start_count;
        int          pick;
        int          run_len;
        int          tick_span;
        int          j;
        logic [31:0] seq;
        bit          corrupt;
        start_count = items_sent;
        tick_span = (cur_timeout <= 16'd1) ? 3 : ((cur_timeout > 16'd37) ? 40 : cur_timeout + 3);
        while (items_sent - start_count < quota) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                corrupt = ($urandom_range(99) < 15);
                case ($urandom_range(9))
                    7:       seq = 32'd0;
                    8:       seq = 32'hFFFF_FFFF;
                    9:       seq = $urandom;
                    default: seq = last_sent_seq + 32'd1;
                endcase
                send_frame(cur_sync, {$urandom, seq, $urandom, $urandom, $urandom}, corrupt, 5);
                if (!corrupt)
                    last_sent_seq = seq;
            end else if (pick < 78) begin
                // Line noise; mostly dropped while hunting.
                run_len = $urandom_range(1, 4);
                for (j = 0; j < run_len; j++)
                    send_word(1'b0, 8'($urandom), 1'b0);
            end else if (pick < 92) begin
                run_len = $urandom_range(1, tick_span);
                for (j = 0; j < run_len; j++)
                    send_word(1'b1, 8'($urandom), 1'b1);
            end else begin
                // A frame cut short; the following words complete it as garbage.
                send_word(1'b0, cur_sync, 1'b1);
                run_len = $urandom_range(0, 21);
                for (j = 0; j < run_len; j++)
                    send_word(1'b0, 8'($urandom), 1'b1);
            end
        end
    endtask

    initial begin
        int seg;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames with the reset register values: field extremes and sequence cases.
        send_word(1'b0, 8'h00, 1'b0);
        send_word(1'b0, 8'hFF, 1'b0);
        send_frame(8'hAA, {32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0, 0);
        // Sync value inside the payload and as part of the data.
        send_frame(8'hAA, {32'hAAAA_AAAA, 32'd2, 32'h0000_00AA, 32'hAA00_0000, 32'd0}, 0, 0);
        send_frame(8'hAA, {32'h1, 32'd7, 32'h2, 32'h3, 32'h4}, 0, 0);
        send_frame(8'hAA, {32'h5, 32'd8, 32'h6, 32'h7, 32'h8}, 1, 0);
        send_frame(8'hAA, {32'h9, 32'hFFFF_FFFF, 32'hA, 32'hB, 32'hC}, 0, 0);
        send_frame(8'hAA, {32'hD, 32'd0, 32'hE, 32'hF, 32'h10}, 0, 0);
        send_frame(8'hAA, {32'h11, 32'h1234, 32'h12, 32'h13, 32'h14}, 0, 0);
        last_sent_seq = 32'h1234;

        // Timeout of one tick: repeated ticks report once, a byte re-arms, mid-frame ticks.
        settle();
        write_config(8'hAA, 16'd1);
        send_word(1'b1, 8'h00, 1'b1);
        send_word(1'b1, 8'hFF, 1'b1);
        send_word(1'b0, 8'h01, 1'b0);
        send_word(1'b1, 8'h00, 1'b1);
        send_frame(8'hAA, {32'h21, 32'h1235, 32'h22, 32'h23, 32'h24}, 0, 30);
        last_sent_seq = 32'h1235;

        // A timeout setting of zero, and a sync value of zero.
        settle();
        write_config(8'h00, 16'd0);
        send_word(1'b1, 8'h00, 1'b1);
        send_word(1'b1, 8'h00, 1'b1);
        send_frame(8'h00, {32'h31, 32'h1236, 32'h32, 32'h33, 32'h34}, 0, 0);
        last_sent_seq = 32'h1236;

        // Random part: six register settings over three flow-control modes.
        for (seg = 0; seg < 6; seg++) begin
            settle();
            if (seg == 2) begin
                send_gap_pct = 73;
                recv_stall_pct = 32;
            end else if (seg == 4) begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            case (seg)
                0:       write_config(8'hFF, 16'd1);
                1:       write_config(8'($urandom), 16'($urandom_range(2, 20)));
                2:       write_config(8'($urandom), 16'd0);
                3:       write_config(8'hAA, 16'($urandom_range(1, 40)));
                4:       write_config(8'($urandom), 16'hFFFF);
                default: write_config(8'h55, 16'($urandom_range(1, 10)));
            endcase
            random_traffic(SEGMENT_ITEMS);
        end

        settle();
        $display("Covered %0d words in %0d frames under three flow-control modes.",
                 words_sent, frames_sent);
        $display("Results: %0d good (%0d with skipped sequence), %0d bad checksum, %0d timeouts.",
                 good_count, skip_count, bad_sum_count, timeout_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d checks failed.", fail_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
